// ===== src/podc_pkg.sv =====
// podc_pkg: constants, codes and types for the pop order discipline checker
// no dependencies
package podc_pkg;
   localparam int DEPTH     = 256;
   localparam int KEY_WIDTH = 32;
   localparam int PTR_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_START  = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      VERDICT_IMPOSSIBLE = 3'd0,
      VERDICT_UNSURE     = 3'd1,
      VERDICT_QUEUE      = 3'd2,
      VERDICT_STACK      = 3'd3,
      VERDICT_PRIORITY   = 3'd4
   } verdict_type;

   typedef logic [KEY_WIDTH-1:0] key_type;

   // broadcast from the controller to every sorted cell
   typedef struct packed {
      logic    ins;
      logic    rem;
      logic    clr;
      key_type key;
   } cell_cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0] verdict;
      logic       may_be_queue;
      logic       may_be_stack;
      logic       may_be_priority;
      logic       overflow;
   } rsp_type;
endpackage

// ===== src/podc_if.sv =====
// podc_if: valid/ready channel carrying one payload
// depends on podc_pkg for the payload types
interface podc_req_if;
   logic               valid;
   logic               ready;
   podc_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface podc_rsp_if;
   logic               valid;
   logic               ready;
   podc_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/podc_cell.sv =====
// podc_cell: one slot of the descending sorted chain for the max order
// depends on podc_pkg
module podc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  podc_pkg::cell_cmd_type cmd,
   input  podc_pkg::key_type      left_key,
   input  logic                   left_full,
   input  podc_pkg::key_type      right_key,
   input  logic                   right_full,
   output podc_pkg::key_type      key_out,
   output logic                   full_out
);
   import podc_pkg::*;

   key_type key_ff, key_in;
   logic    full_ff, full_in;
   logic    lt, left_lt;

   // an empty cell counts as smaller than any new key
   assign lt      = !full_ff || (key_ff < cmd.key);
   assign left_lt = left_full && (left_key < cmd.key);

   // insert: smaller keys move one cell right and the new key fills the gap
   // remove: every cell takes its right neighbor, dropping the maximum in cell 0
   always_comb begin
      key_in  = key_ff;
      full_in = full_ff;
      if (cmd.clr) begin
         full_in = 1'b0;
      end else if (cmd.ins) begin
         if (lt && (full_ff || left_full)) begin
            key_in  = left_lt ? left_key : cmd.key;
            full_in = 1'b1;
         end
      end else if (cmd.rem) begin
         key_in  = right_key;
         full_in = right_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else       full_ff <= full_in;
      key_ff <= key_in;
   end

   assign key_out  = key_ff;
   assign full_out = full_ff;
endmodule

// ===== src/podc_chain.sv =====
// podc_chain: row of sorted cells, largest key in cell 0, full cells form a prefix
// depends on podc_pkg and podc_cell
module podc_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  podc_pkg::cell_cmd_type cmd,
   output podc_pkg::key_type      top_key
);
   import podc_pkg::*;

   key_type keys  [DEPTH];
   logic    fulls [DEPTH];
   logic    left_full_v [DEPTH];
   key_type left_key_v  [DEPTH];
   logic    right_full_v[DEPTH];
   key_type right_key_v [DEPTH];

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_l0
            // leftmost cell has an always-full neighbor no smaller than any key
            assign left_full_v[g] = 1'b1;
            assign left_key_v[g]  = '1;
         end else begin : g_ln
            assign left_full_v[g] = fulls[g-1];
            assign left_key_v[g]  = keys[g-1];
         end
         if (g == DEPTH-1) begin : g_rl
            assign right_full_v[g] = 1'b0;
            assign right_key_v[g]  = '0;
         end else begin : g_rn
            assign right_full_v[g] = fulls[g+1];
            assign right_key_v[g]  = keys[g+1];
         end
         podc_cell u_cell (
            .clock, .reset, .cmd,
            .left_key  (left_key_v[g]),  .left_full (left_full_v[g]),
            .right_key (right_key_v[g]), .right_full(right_full_v[g]),
            .key_out   (keys[g]),        .full_out  (fulls[g])
         );
      end
   endgenerate

   // the maximum always sits in the first cell
   assign top_key = keys[0];
endmodule

// ===== src/pop_order_discipline_checker.sv =====
// pop_order_discipline_checker: takes a new request only after the last result is taken, result registered
// idle cycle takes the request, execute cycle compares and updates all stores
// the sorted chain shifts its cells in the execute cycle; a new request is taken in IDLE
// the result is registered in EXEC and shown valid in OUT; held until taken
// reset (synchronous) clears count, pointers and overflow and sets all three ok flags
module pop_order_discipline_checker (
   input logic clock,
   input logic reset,
   podc_req_if.sink   req,
   podc_rsp_if.source rsp
);
   import podc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_type;

   state_type   state_ff;
   req_type     item_ff;
   key_type     fifo_mem [DEPTH];
   key_type     lifo_mem [DEPTH];
   key_type     fifo_rd_ff, lifo_rd_ff;
   logic [PTR_W-1:0] head_ff, tail_ff;
   logic [CNT_W-1:0] count_ff;
   logic        q_ok_ff, s_ok_ff, p_ok_ff, ovf_ff;
   rsp_type     rsp_ff;
   cell_cmd_type cmd;
   key_type     top_key;
   logic [PTR_W-1:0] top_idx;
   logic        q_in, s_in, p_in, o_in, full, empty;
   logic [1:0]  n;
   key_type     key;

   assign key     = item_ff.value[KEY_WIDTH-1:0];
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign top_idx = PTR_W'(count_ff - CNT_W'(1));

   // chain command only in the execute cycle
   always_comb begin
      cmd.key = key;
      cmd.clr = (state_ff == S_EXEC) && (item_ff.kind == KIND_START);
      cmd.ins = (state_ff == S_EXEC) && (item_ff.kind == KIND_INSERT) && !full;
      cmd.rem = (state_ff == S_EXEC) && (item_ff.kind == KIND_REMOVE) && !empty;
   end

   podc_chain u_chain (.clock, .reset, .cmd, .top_key);

   // flag update
   always_comb begin
      q_in = q_ok_ff; s_in = s_ok_ff; p_in = p_ok_ff; o_in = ovf_ff;
      case (item_ff.kind)
         KIND_START:  begin q_in = 1'b1; s_in = 1'b1; p_in = 1'b1; o_in = 1'b0; end
         KIND_INSERT: begin if (full) o_in = 1'b1; end
         KIND_REMOVE: begin
            if (empty) begin
               q_in = 1'b0; s_in = 1'b0; p_in = 1'b0;
            end else begin
               if (fifo_rd_ff != key) q_in = 1'b0;
               if (lifo_rd_ff != key) s_in = 1'b0;
               if (top_key != key)    p_in = 1'b0;
            end
         end
         default: ;
      endcase
      n = 2'(q_in) + 2'(s_in) + 2'(p_in);
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data  = rsp_ff;

   // memories: read ports registered in the accept cycle
   always_ff @(posedge clock) begin
      fifo_rd_ff <= fifo_mem[head_ff];
      lifo_rd_ff <= lifo_mem[top_idx];
      if (cmd.ins) begin
         fifo_mem[tail_ff] <= key;
         lifo_mem[count_ff[PTR_W-1:0]] <= key;
      end
   end

   // control state and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0; tail_ff <= '0; count_ff <= '0;
         q_ok_ff <= 1'b1; s_ok_ff <= 1'b1; p_ok_ff <= 1'b1; ovf_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (req.valid) begin
               item_ff  <= req.data;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               q_ok_ff <= q_in; s_ok_ff <= s_in; p_ok_ff <= p_in; ovf_ff <= o_in;
               if (cmd.clr) begin
                  head_ff <= '0; tail_ff <= '0; count_ff <= '0;
               end
               if (cmd.ins) begin
                  tail_ff  <= (tail_ff == PTR_W'(DEPTH-1)) ? '0 : tail_ff + PTR_W'(1);
                  count_ff <= count_ff + CNT_W'(1);
               end
               if (cmd.rem) begin
                  head_ff  <= (head_ff == PTR_W'(DEPTH-1)) ? '0 : head_ff + PTR_W'(1);
                  count_ff <= count_ff - CNT_W'(1);
               end
               rsp_ff.may_be_queue    <= q_in;
               rsp_ff.may_be_stack    <= s_in;
               rsp_ff.may_be_priority <= p_in;
               rsp_ff.overflow        <= o_in;
               if (n == 2'd0)     rsp_ff.verdict <= VERDICT_IMPOSSIBLE;
               else if (n > 2'd1) rsp_ff.verdict <= VERDICT_UNSURE;
               else if (q_in)     rsp_ff.verdict <= VERDICT_QUEUE;
               else if (s_in)     rsp_ff.verdict <= VERDICT_STACK;
               else               rsp_ff.verdict <= VERDICT_PRIORITY;
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp.ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("count beyond depth");
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(state_ff == S_EXEC)) else $error("result without execute");
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.clr |=> count_ff == '0 && q_ok_ff && s_ok_ff && p_ok_ff && !ovf_ff)
      else $error("start did not clear");
   a_full_no_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && full && item_ff.kind == KIND_INSERT) |=> ovf_ff && full)
      else $error("overflow insert mishandled");
endmodule
